// ===== hw/rtl/stcg_pkg.sv =====
// ----------------------------------------------------------------------------
// stcg_pkg
// Shared types and constants of the stabilizer tableau Clifford gate unit.
// ----------------------------------------------------------------------------
package stcg_pkg;

  // payload field widths
  localparam int ModeW    = 2;
  localparam int QubitW   = 5;
  localparam int RowSelW  = 6;
  localparam int PhaseW   = 2;

  // largest tableau the field widths can address
  localparam int MaxQubits         = 32;
  localparam int NumQubitsDefault  = 32;

  typedef enum logic [ModeW-1:0] {
    MODE_HADAMARD = 2'd0,
    MODE_PHASE    = 2'd1,
    MODE_CNOT     = 2'd2,
    MODE_READ     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

endpackage

// ===== hw/rtl/stcg_if.sv =====
// ----------------------------------------------------------------------------
// stcg_in_if / stcg_out_if
// Valid/ready channels carrying tableau requests and their results.
// ----------------------------------------------------------------------------
interface stcg_in_if;
  logic                            valid;
  logic                            ready;
  logic [stcg_pkg::ModeW-1:0]      mode;
  logic [stcg_pkg::QubitW-1:0]     qubit_a;
  logic [stcg_pkg::QubitW-1:0]     qubit_b;
  logic [stcg_pkg::RowSelW-1:0]    row_sel;

  modport source (output valid, mode, qubit_a, qubit_b, row_sel, input ready);
  modport sink   (input valid, mode, qubit_a, qubit_b, row_sel, output ready);
endinterface

interface stcg_out_if;
  logic                            valid;
  logic                            ready;
  logic                            x_bit;
  logic                            z_bit;
  logic [stcg_pkg::PhaseW-1:0]     row_phase_out;
  logic                            done_res;

  modport source (output valid, x_bit, z_bit, row_phase_out, done_res, input ready);
  modport sink   (input valid, x_bit, z_bit, row_phase_out, done_res, output ready);
endinterface

// ===== hw/rtl/stcg_colmem.sv =====
// ----------------------------------------------------------------------------
// stcg_colmem
// Column store of one tableau half: one word per qubit, one bit per row.
// Two registered read ports, one write port; unwritten columns read as the
// identity column (single bit at row q + Offset).
// ----------------------------------------------------------------------------
module stcg_colmem #(
  parameter int NumQubits = stcg_pkg::NumQubitsDefault,
  parameter int Offset    = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [$clog2(NumQubits)-1:0]      rd_addr0_i,
  input  logic [$clog2(NumQubits)-1:0]      rd_addr1_i,
  output logic [2*NumQubits-1:0]            rd_data0_o,
  output logic [2*NumQubits-1:0]            rd_data1_o,
  input  logic                              wr_en_i,
  input  logic [$clog2(NumQubits)-1:0]      wr_addr_i,
  input  logic [2*NumQubits-1:0]            wr_data_i
);

  localparam int Rows = 2 * NumQubits;
  localparam int QW   = $clog2(NumQubits);
  localparam int RW   = $clog2(Rows);

  logic [Rows-1:0]     mem_q [NumQubits];
  logic [NumQubits-1:0] vld_q;

  logic [Rows-1:0] rdata0_q, rdata1_q;
  logic            rvld0_q, rvld1_q;
  logic [QW-1:0]   raddr0_q, raddr1_q;
  logic [RW-1:0]   init_idx0, init_idx1;
  logic [Rows-1:0] init0, init1;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata0_q <= mem_q[rd_addr0_i];
      rdata1_q <= mem_q[rd_addr1_i];
      raddr0_q <= rd_addr0_i;
      raddr1_q <= rd_addr1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rvld0_q <= 1'b0;
      rvld1_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld0_q <= vld_q[rd_addr0_i];
        rvld1_q <= vld_q[rd_addr1_i];
      end
    end
  end

  // identity column for a never-written entry
  always_comb begin
    init_idx0 = RW'(raddr0_q) + RW'(Offset);
    init_idx1 = RW'(raddr1_q) + RW'(Offset);
    init0 = '0;
    init1 = '0;
    init0[init_idx0] = 1'b1;
    init1[init_idx1] = 1'b1;
  end

  assign rd_data0_o = rvld0_q ? rdata0_q : init0;
  assign rd_data1_o = rvld1_q ? rdata1_q : init1;

endmodule

// ===== hw/rtl/stabilizer_tableau_clifford_gates_unit.sv =====
// ----------------------------------------------------------------------------
// stabilizer_tableau_clifford_gates_unit
// Stabilizer tableau with Hadamard, phase and CNOT updates over all rows and
// single-entry reads. X and Z bits live in column memories; row phases in a
// register word.
//
//   channel  dir  payload                                   transfer when
//   in_i     in   mode, qubit_a, qubit_b, row_sel           valid && ready
//   out_o    out  x_bit, z_bit, row_phase_out, done_res     valid && ready
//
// An item passes through accept, column read and update/write-back; these
// steps form a single read-modify-write pass through the column memories.
// A new item is accepted while a result waits in the output register; the
// write-back stalls until that register is free.
// Reset gives the identity tableau at once via per-column valid bits.
// ----------------------------------------------------------------------------
module stabilizer_tableau_clifford_gates_unit #(
  parameter int NumQubits = stcg_pkg::NumQubitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  stcg_in_if.sink     in_i,
  stcg_out_if.source  out_o
);

  localparam int Rows    = 2 * NumQubits;
  localparam int QW      = $clog2(NumQubits);
  localparam int RW      = $clog2(Rows);
  localparam int QCmpW   = stcg_pkg::QubitW + 1;
  localparam int RCmpW   = stcg_pkg::RowSelW + 1;

  stcg_pkg::state_e state_q, state_d;
  stcg_pkg::mode_e  op_q;

  logic [QW-1:0]   a_q, b_q;
  logic [RW-1:0]   row_q;
  logic            a_ok_q, b_ok_q, row_ok_q;
  logic            in_xfer, out_free;

  logic [Rows-1:0] ph_q, ph_d;

  logic            rd_en;
  logic [Rows-1:0] xa, xb, za, zb;
  logic            x_we, z_we;
  logic [QW-1:0]   x_waddr;
  logic [Rows-1:0] x_wdata, z_wdata;
  logic [Rows-1:0] flips;
  logic [Rows-1:0] xb_new, za_new;
  logic            fire;

  logic            out_vld_q;
  logic            x_bit_q, z_bit_q;
  logic [stcg_pkg::PhaseW-1:0] phase_q;
  logic            rd_hit;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;

  // ---------------- control ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stcg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_i.ready  = 1'b0;
    rd_en       = 1'b0;
    fire        = 1'b0;
    unique case (state_q)
      stcg_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = stcg_pkg::ST_READ;
        end
      end
      stcg_pkg::ST_READ: begin
        rd_en   = 1'b1;
        state_d = stcg_pkg::ST_EXEC;
      end
      stcg_pkg::ST_EXEC: begin
        if (out_free) begin
          fire    = 1'b1;
          state_d = stcg_pkg::ST_IDLE;
        end
      end
      default: state_d = stcg_pkg::ST_IDLE;
    endcase
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q     <= stcg_pkg::mode_e'(in_i.mode);
      a_q      <= in_i.qubit_a[QW-1:0];
      b_q      <= in_i.qubit_b[QW-1:0];
      row_q    <= in_i.row_sel[RW-1:0];
      a_ok_q   <= QCmpW'(in_i.qubit_a) < QCmpW'(NumQubits);
      b_ok_q   <= QCmpW'(in_i.qubit_b) < QCmpW'(NumQubits);
      row_ok_q <= RCmpW'(in_i.row_sel) < RCmpW'(Rows);
    end
  end

  // ---------------- column stores ----------------
  stcg_colmem #(
    .NumQubits (NumQubits),
    .Offset    (0)
  ) u_xmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr0_i (a_q),
    .rd_addr1_i (b_q),
    .rd_data0_o (xa),
    .rd_data1_o (xb),
    .wr_en_i    (x_we),
    .wr_addr_i  (x_waddr),
    .wr_data_i  (x_wdata)
  );

  stcg_colmem #(
    .NumQubits (NumQubits),
    .Offset    (NumQubits)
  ) u_zmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr0_i (a_q),
    .rd_addr1_i (b_q),
    .rd_data0_o (za),
    .rd_data1_o (zb),
    .wr_en_i    (z_we),
    .wr_addr_i  (a_q),
    .wr_data_i  (z_wdata)
  );

  // ---------------- gate update ----------------
  assign xb_new = xb ^ xa;
  assign za_new = za ^ zb;

  always_comb begin
    x_we    = 1'b0;
    z_we    = 1'b0;
    x_waddr = a_q;
    x_wdata = za;
    z_wdata = xa;
    flips   = '0;
    case (op_q)
      stcg_pkg::MODE_HADAMARD: begin
        x_we    = fire && a_ok_q;
        z_we    = fire && a_ok_q;
        x_wdata = za;
        z_wdata = xa;
        flips   = xa & za;
      end
      stcg_pkg::MODE_PHASE: begin
        z_we    = fire && a_ok_q;
        z_wdata = za ^ xa;
        flips   = xa & za;
      end
      stcg_pkg::MODE_CNOT: begin
        x_we    = fire && a_ok_q && b_ok_q && (a_q != b_q);
        z_we    = x_we;
        x_waddr = b_q;
        x_wdata = xb_new;
        z_wdata = za_new;
        flips   = xa & zb & ~(xb_new ^ za_new);
      end
      default: begin
      end
    endcase
  end

  // phase is always 0 or 2, so only its high bit is kept per row
  assign ph_d = z_we ? (ph_q ^ flips) : ph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= '0;
    end else begin
      ph_q <= ph_d;
    end
  end

  // ---------------- result register ----------------
  assign rd_hit = (op_q == stcg_pkg::MODE_READ) && a_ok_q && row_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      x_bit_q <= rd_hit && xa[row_q];
      z_bit_q <= rd_hit && za[row_q];
      phase_q <= {rd_hit && ph_q[row_q], 1'b0};
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.x_bit         = x_bit_q;
  assign out_o.z_bit         = z_bit_q;
  assign out_o.row_phase_out = phase_q;
  assign out_o.done_res      = 1'b1;

  // ---------------- assertions ----------------
  a_accept_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == stcg_pkg::ST_READ)
    else $error("accepted item did not start a column read");

  a_write_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_we || z_we) |-> (state_q == stcg_pkg::ST_EXEC) && out_free)
    else $error("write-back without a free result slot");

  a_gate_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) && (op_q != stcg_pkg::MODE_READ) |->
      !x_bit_q && !z_bit_q && (phase_q == '0))
    else $error("gate item returned nonzero read data");

  a_phase_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !phase_q[0])
    else $error("odd row phase reported");

  a_result_follows_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q && state_q == stcg_pkg::ST_IDLE)
    else $error("result not loaded after update");

endmodule

// ===== sim/stabilizer_tableau_clifford_gates_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stabilizer_tableau_clifford_gates_unit_tb
// Self-checking bench for the tableau unit. A directed table (reset reads,
// gate chains, cnot on equal qubits, ignored fields at their extremes) is
// followed by random gate/read traffic. A local copy of the tableau predicts
// each untyped result. The sender works in bursts, the receiver stalls on its own
// pattern, and one long receiver hold-off backs up the input channel.
// ----------------------------------------------------------------------------
module stabilizer_tableau_clifford_gates_unit_tb;
  import stcg_pkg::*;

  localparam int NQ          = NumQubitsDefault;
  localparam int NumRows     = 2 * NQ;
  localparam int RandItems   = 650;
  localparam int IdleLimit   = 1000;
  localparam int HoldCycles  = 300;
  localparam int HoldAfter   = 200;
  localparam int DrainCycles = 10;

  typedef struct packed {
    mode_e                mode;
    logic [QubitW-1:0]    qa;
    logic [QubitW-1:0]    qb;
    logic [RowSelW-1:0]   row;
  } req_t;

  typedef struct packed {
    logic                 x;
    logic                 z;
    logic [PhaseW-1:0]    ph;
    logic                 done;
  } res_t;

  typedef struct packed {
    req_t  rq;
    logic  typed;
    res_t  res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  stcg_in_if  in_if ();
  stcg_out_if out_if ();

  stabilizer_tableau_clifford_gates_unit #(
    .NumQubits (NQ)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // local tableau copy, column organized like the block
  logic [63:0]       x_col [MaxQubits];
  logic [63:0]       z_col [MaxQubits];
  logic [PhaseW-1:0] row_ph [64];

  res_t     pending_results [$];
  dir_row_t dir_tab [$];
  int       err_cnt = 0;
  int       results_seen = 0;
  int       burst_left = 0;

  function automatic logic [63:0] live_rows();
    if (NumRows >= 64) return '1;
    return (64'd1 << NumRows) - 64'd1;
  endfunction

  function automatic void add_two(logic [63:0] flips);
    for (int r = 0; r < 64; r++)
      if (flips[r]) row_ph[r] = row_ph[r] + 2'd2;
  endfunction

  // applies one request to the local tableau and returns its result
  function automatic res_t tableau_step(req_t rq);
    logic [63:0] m, xa, za, xb, zb;
    res_t res;
    res = '0;
    res.done = 1'b1;
    m = live_rows();
    case (rq.mode)
      MODE_HADAMARD: begin
        if (rq.qa < NQ) begin
          xa = x_col[rq.qa];
          za = z_col[rq.qa];
          add_two(xa & za & m);
          x_col[rq.qa] = (xa & ~m) | (za & m);
          z_col[rq.qa] = (za & ~m) | (xa & m);
        end
      end
      MODE_PHASE: begin
        if (rq.qa < NQ) begin
          xa = x_col[rq.qa];
          add_two(xa & z_col[rq.qa] & m);
          z_col[rq.qa] = z_col[rq.qa] ^ (xa & m);
        end
      end
      MODE_CNOT: begin
        if (rq.qa < NQ && rq.qb < NQ && rq.qa != rq.qb) begin
          xa = x_col[rq.qa];
          zb = z_col[rq.qb];
          xb = x_col[rq.qb] ^ (xa & m);
          za = z_col[rq.qa] ^ (zb & m);
          x_col[rq.qb] = xb;
          z_col[rq.qa] = za;
          add_two(xa & zb & ~(xb ^ za) & m);
        end
      end
      default: begin
        if (rq.qa < NQ && rq.row < NumRows) begin
          res.x  = x_col[rq.qa][rq.row];
          res.z  = z_col[rq.qa][rq.row];
          res.ph = row_ph[rq.row];
        end
      end
    endcase
    return res;
  endfunction

  function automatic dir_row_t dir_row(mode_e m, int a, int b, int row, bit typed = 1'b0,
                                       bit x = 1'b0, bit z = 1'b0, int ph = 0);
    dir_row_t d;
    d.rq.mode   = m;
    d.rq.qa     = QubitW'(a);
    d.rq.qb     = QubitW'(b);
    d.rq.row    = RowSelW'(row);
    d.typed     = typed;
    d.res.x     = x;
    d.res.z     = z;
    d.res.ph    = PhaseW'(ph);
    d.res.done  = 1'b1;
    return d;
  endfunction

  // offer one request, wait for its transfer, then maybe idle
  task automatic send_req(req_t rq, logic typed, res_t typed_res);
    res_t pred;
    int   gap;
    in_if.valid   <= 1'b1;
    in_if.mode    <= rq.mode;
    in_if.qubit_a <= rq.qa;
    in_if.qubit_b <= rq.qb;
    in_if.row_sel <= rq.row;
    do @(posedge clk); while (!in_if.ready);
    pred = tableau_step(rq);
    pending_results.push_back(typed ? typed_res : pred);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    req_t rq;
    int   qmax;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.mode     = MODE_HADAMARD;
    in_if.qubit_a  = '0;
    in_if.qubit_b  = '0;
    in_if.row_sel  = '0;
    for (int q = 0; q < MaxQubits; q++) begin
      x_col[q] = (q < NQ) ? (64'd1 << q) : '0;
      z_col[q] = (q < NQ) ? (64'd1 << (NQ + q)) : '0;
    end
    for (int r = 0; r < 64; r++) row_ph[r] = '0;

    // identity tableau reads, then gate chains checked by the predictor
    dir_tab.push_back(dir_row(MODE_READ, 0, 0, 0, 1, 1, 0, 0));
    dir_tab.push_back(dir_row(MODE_READ, 31, 0, 31, 1, 1, 0, 0));
    dir_tab.push_back(dir_row(MODE_READ, 31, 31, 63, 1, 0, 1, 0));
    dir_tab.push_back(dir_row(MODE_READ, 0, 31, 63, 1, 0, 0, 0));
    dir_tab.push_back(dir_row(MODE_READ, 17, 0, 49, 1, 0, 1, 0));
    dir_tab.push_back(dir_row(MODE_HADAMARD, 0, 0, 0));
    dir_tab.push_back(dir_row(MODE_READ, 0, 0, 0));
    dir_tab.push_back(dir_row(MODE_READ, 0, 0, 32));
    dir_tab.push_back(dir_row(MODE_PHASE, 0, 0, 0));
    dir_tab.push_back(dir_row(MODE_HADAMARD, 0, 0, 0));
    dir_tab.push_back(dir_row(MODE_READ, 0, 0, 32));
    dir_tab.push_back(dir_row(MODE_CNOT, 0, 31, 0));
    dir_tab.push_back(dir_row(MODE_CNOT, 31, 0, 0));
    // cnot on equal qubits leaves the tableau alone
    dir_tab.push_back(dir_row(MODE_CNOT, 5, 5, 0));
    dir_tab.push_back(dir_row(MODE_READ, 31, 0, 32));
    dir_tab.push_back(dir_row(MODE_PHASE, 31, 0, 0));
    dir_tab.push_back(dir_row(MODE_CNOT, 31, 30, 0));
    dir_tab.push_back(dir_row(MODE_HADAMARD, 31, 0, 0));
    dir_tab.push_back(dir_row(MODE_READ, 31, 0, 63));
    dir_tab.push_back(dir_row(MODE_READ, 30, 0, 0));
    // ignored fields at all ones on gates
    dir_tab.push_back(dir_row(MODE_HADAMARD, 31, 31, 63));
    dir_tab.push_back(dir_row(MODE_PHASE, 0, 31, 63));
    dir_tab.push_back(dir_row(MODE_READ, 0, 31, 32));
    dir_tab.push_back(dir_row(MODE_READ, 31, 31, 63));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].res);
    drain();

    for (int i = 0; i < RandItems; i++) begin
      if (i == RandItems / 2) drain();
      // a narrow qubit set piles gates onto the same columns
      qmax = ($urandom_range(0, 2) == 0) ? 3 : MaxQubits - 1;
      rq.mode = ($urandom_range(0, 99) < 35) ? MODE_READ : mode_e'(ModeW'($urandom_range(0, 2)));
      rq.qa   = QubitW'($urandom_range(0, qmax));
      rq.qb   = ($urandom_range(0, 9) == 0) ? rq.qa : QubitW'($urandom_range(0, qmax));
      rq.row  = RowSelW'($urandom_range(0, 63));
      send_req(rq, 1'b0, '0);
    end
    drain();

    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // receiver: changing stall patterns, plus one long hold-off
  initial begin
    int  stall_kind;
    int  kind_left;
    int  cyc;
    bit  hold_done;
    stall_kind   = 0;
    kind_left    = 0;
    cyc          = 0;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (!hold_done && results_seen >= HoldAfter) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        if (kind_left == 0) begin
          stall_kind = $urandom_range(0, 3);
          kind_left  = $urandom_range(20, 120);
        end
        kind_left--;
        case (stall_kind)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= (cyc % 4 == 0);
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending: x %0b z %0b phase %0d done %0b", $time,
                 out_if.x_bit, out_if.z_bit, out_if.row_phase_out, out_if.done_res);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.x_bit !== want.x) begin
          $display("%0t: x_bit expected %0b actual %0b", $time, want.x, out_if.x_bit);
          err_cnt++;
        end
        if (out_if.z_bit !== want.z) begin
          $display("%0t: z_bit expected %0b actual %0b", $time, want.z, out_if.z_bit);
          err_cnt++;
        end
        if (out_if.row_phase_out !== want.ph) begin
          $display("%0t: row_phase_out expected %0d actual %0d", $time, want.ph,
                   out_if.row_phase_out);
          err_cnt++;
        end
        if (out_if.done_res !== want.done) begin
          $display("%0t: done_res expected %0b actual %0b", $time, want.done,
                   out_if.done_res);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    int idle_cnt;
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/stcg_pkg.sv
hw/rtl/stcg_if.sv
hw/rtl/stcg_colmem.sv
hw/rtl/stabilizer_tableau_clifford_gates_unit.sv
sim/stabilizer_tableau_clifford_gates_unit_tb.sv
